### src/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Types, constants and the key map shared by the keypad scanner files.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned COL_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
  localparam logic [COUNT_W-1:0] RELEASE_LIMIT_RST = 16'd100;
  localparam logic [COUNT_W-1:0] REPEAT_LIMIT_RST  = 16'd500;

  localparam logic [KEY_W-1:0] KEY_NONE = 7'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT  = 2'd1;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] held;
    logic [COUNT_W-1:0] idle;
  } kpd_state_t;

  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_code;
    logic [ROW_W-1:0] row_drive;
  } kpd_result_t;

  localparam kpd_state_t STATE_RST = '{row: '0, key: KEY_NONE, held: '0, idle: '0};

  // rows down, columns across
  function automatic logic [KEY_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
                                                 input logic [1:0] col);
    logic [KEY_W-1:0] code;
    case ({row, col})
      4'h0: code = 7'h31;  // '1'
      4'h1: code = 7'h34;  // '4'
      4'h2: code = 7'h37;  // '7'
      4'h3: code = 7'h2A;  // '*'
      4'h4: code = 7'h32;  // '2'
      4'h5: code = 7'h35;  // '5'
      4'h6: code = 7'h38;  // '8'
      4'h7: code = 7'h30;  // '0'
      4'h8: code = 7'h33;  // '3'
      4'h9: code = 7'h36;  // '6'
      4'hA: code = 7'h39;  // '9'
      4'hB: code = 7'h23;  // '#'
      4'hC: code = 7'h41;  // 'A'
      4'hD: code = 7'h42;  // 'B'
      4'hE: code = 7'h43;  // 'C'
      4'hF: code = 7'h44;  // 'D'
      default: code = KEY_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v != COUNT_MAX) ? v + COUNT_W'(1) : v;
  endfunction

endpackage

### src/kpd_in_if.sv
// ----------------------------------------------------------------------------
// kpd_in_if
// Scan tick channel: sampled column bits of the driven row.
// ----------------------------------------------------------------------------
interface kpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [kpd_pkg::COL_W-1:0]   column_bits;

  modport source (output valid, output column_bits, input ready);
  modport sink   (input valid, input column_bits, output ready);
endinterface

### src/kpd_out_if.sv
// ----------------------------------------------------------------------------
// kpd_out_if
// Result channel: registered key press and next row to drive.
// ----------------------------------------------------------------------------
interface kpd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        key_valid;
  logic [kpd_pkg::KEY_W-1:0]   key_code;
  logic [kpd_pkg::ROW_W-1:0]   row_drive;

  modport source (output valid, output key_valid, output key_code, output row_drive,
                  input ready);
  modport sink   (input valid, input key_valid, input key_code, input row_drive,
                  output ready);
endinterface

### src/kpd_cfg_if.sv
// ----------------------------------------------------------------------------
// kpd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface kpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kpd_pkg::CFG_IDX_W-1:0] index;
  logic [kpd_pkg::COUNT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/kpd_core.sv
// ----------------------------------------------------------------------------
// kpd_core
// Key decode and debounce counter update for one scan tick.
// ----------------------------------------------------------------------------
module kpd_core (
  input  kpd_pkg::kpd_state_t          state_i,
  input  logic [kpd_pkg::COL_W-1:0]    column_bits,
  input  logic [kpd_pkg::COUNT_W-1:0]  release_limit,
  input  logic [kpd_pkg::COUNT_W-1:0]  repeat_limit,
  output kpd_pkg::kpd_state_t          state_o,
  output kpd_pkg::kpd_result_t         result_o
);
  import kpd_pkg::*;

  logic [KEY_W-1:0] key;
  logic             fire;

  // exactly one closed column names a key; anything else is keyless
  always_comb begin
    case (column_bits)
      4'b0001: key = key_lookup(state_i.row, 2'd0);
      4'b0010: key = key_lookup(state_i.row, 2'd1);
      4'b0100: key = key_lookup(state_i.row, 2'd2);
      4'b1000: key = key_lookup(state_i.row, 2'd3);
      default: key = KEY_NONE;
    endcase
  end

  always_comb begin
    state_o = state_i;
    fire    = 1'b0;
    if (key == KEY_NONE) begin
      if (state_i.idle > release_limit) begin
        state_o.key  = KEY_NONE;
        state_o.held = '0;
        state_o.idle = '0;
      end else begin
        state_o.idle = sat_inc(state_i.idle);
      end
    end else if (state_i.key != key) begin
      fire = 1'b1;
    end else if (state_i.held > repeat_limit) begin
      fire = 1'b1;
    end else begin
      state_o.held = sat_inc(state_i.held);
    end

    if (fire) begin
      state_o.key  = key;
      state_o.held = '0;
      state_o.idle = '0;
    end

    state_o.row = state_i.row + ROW_W'(1);

    result_o.key_valid = fire;
    result_o.key_code  = fire ? key : KEY_NONE;
    result_o.row_drive = state_o.row;
  end

endmodule

### src/keypad_scan_debounce.sv
// ----------------------------------------------------------------------------
// keypad_scan_debounce
// 4x4 matrix keypad scanner with new-key, repeat and release debounce.
// ----------------------------------------------------------------------------
// Every accepted scan tick yields exactly one result, held first in the
// input register and then in the result register. One tick is accepted per
// cycle while the result side is not stalled: the input register feeds a
// single pass of decode, limit compare and counter update straight into the
// result register, and a new tick enters while the previous result still
// waits to be taken. row_drive tells which row to drive for the next tick.
// Limits are written through the cfg channel, which is always ready; writes
// to unknown indexes are dropped. No clearing pass is needed after reset.
module keypad_scan_debounce (
  input logic      clk,
  input logic      rst_n,
  kpd_in_if.sink   in_ch,
  kpd_out_if.source out_ch,
  kpd_cfg_if.sink  cfg_ch
);
  import kpd_pkg::*;

  logic               in_vld_r;
  logic [COL_W-1:0]   col_r;
  logic               out_vld_r;
  kpd_result_t        result_r;
  kpd_result_t        result_nxt;
  kpd_state_t         state_r;
  kpd_state_t         state_nxt;
  logic [COUNT_W-1:0] release_limit_r;
  logic [COUNT_W-1:0] repeat_limit_r;
  logic               adv;
  logic               in_ready;

  // stage 1 moves into the result register when that is free or draining
  assign adv      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ready = !in_vld_r || adv;

  assign in_ch.ready      = in_ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.key_valid = result_r.key_valid;
  assign out_ch.key_code  = result_r.key_code;
  assign out_ch.row_drive = result_r.row_drive;

  kpd_core u_core (
    .state_i       (state_r),
    .column_bits   (col_r),
    .release_limit (release_limit_r),
    .repeat_limit  (repeat_limit_r),
    .state_o       (state_nxt),
    .result_o      (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      state_r         <= STATE_RST;
      release_limit_r <= RELEASE_LIMIT_RST;
      repeat_limit_r  <= REPEAT_LIMIT_RST;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_RELEASE_LIMIT: release_limit_r <= cfg_ch.data;
          CFG_REPEAT_LIMIT:  repeat_limit_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      col_r <= in_ch.column_bits;
    end
    if (adv) begin
      result_r <= result_nxt;
    end
  end

  a_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> state_r.row == $past(state_r.row) + ROW_W'(1))
    else $error("row index did not advance by one per tick");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && result_nxt.key_valid |=> state_r.held == '0 && state_r.idle == '0
                                    && state_r.key == $past(result_nxt.key_code))
    else $error("registration did not clear counters or store key");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !result_r.key_valid |-> result_r.key_code == KEY_NONE)
    else $error("key code set without a registered key");

  a_row_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> result_r.row_drive == state_r.row)
    else $error("row_drive does not match the row index");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule
